// ===== src/tmqs_pkg.sv =====
// Shared constants, codes and control types of the typed message queue store.
package tmqs_pkg;

  localparam int NUM_QUEUES  = 8;
  localparam int QUEUE_DEPTH = 128;
  localparam int MSG_WORDS   = 32;

  localparam int SLOT_W  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int DEPTH_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int WIDX_W  = (MSG_WORDS > 1) ? $clog2(MSG_WORDS) : 1;
  localparam int NW_W    = $clog2(MSG_WORDS + 1);
  localparam int ENT_W   = $clog2(NUM_QUEUES * QUEUE_DEPTH);
  localparam int PAY_AW  = $clog2(NUM_QUEUES * QUEUE_DEPTH * MSG_WORDS);
  localparam int LEN_W   = 9;
  localparam int MAX_BYTES = MSG_WORDS * 8;

  localparam int PADDR_W = 3;
  localparam logic REG_QCOUNT = 1'b0;
  localparam logic REG_QDEPTH = 1'b1;
  localparam logic [3:0] QCOUNT_RST = 4'd5;
  localparam logic [7:0] QDEPTH_RST = 8'd100;

  localparam logic OP_SEND = 1'b0;
  localparam logic OP_RECV = 1'b1;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_QFULL   = 3'd1,
    ST_MAPFULL = 3'd2,
    ST_BAD     = 3'd3,
    ST_EMPTY   = 3'd4,
    ST_SMALL   = 3'd5
  } tmqs_status_e;

  typedef struct packed {
    logic accept;
    logic lookup;
    logic copy;
    logic copy_fl;
    logic len_chk;
    logic emit;
    logic resp;
  } tmqs_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic in_op;
    logic in_last;
    logic op;
    logic lk_ok;
    logic copy_last;
    logic too_small;
    logic emit_last;
    logic out_free;
  } tmqs_sts_t;

endpackage

// ===== src/tmqs_req_if.sv =====
// Request channel: send data words and receive requests.
interface tmqs_req_if;
  import tmqs_pkg::*;
  logic               valid;
  logic               ready;
  logic               op;
  logic signed [31:0] msg_kind;
  logic [63:0]        data_word;
  logic               last_word;
  logic [LEN_W-1:0]   byte_length;
  modport source (output valid, op, msg_kind, data_word, last_word, byte_length,
                  input ready);
  modport sink (input valid, op, msg_kind, data_word, last_word, byte_length,
                output ready);
endinterface

// ===== src/tmqs_rsp_if.sv =====
// Result channel: status and received payload words.
interface tmqs_rsp_if;
  import tmqs_pkg::*;
  logic             valid;
  logic             ready;
  logic [2:0]       status;
  logic [63:0]      out_word;
  logic [LEN_W-1:0] out_length;
  logic             out_last;
  modport source (output valid, status, out_word, out_length, out_last, input ready);
  modport sink (input valid, status, out_word, out_length, out_last, output ready);
endinterface

// ===== src/tmqs_dp.sv =====
// Datapath: slot table, staging buffer, message stores and result register.
module tmqs_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  tmqs_req_if.sink              req,
  tmqs_rsp_if.source            rsp,
  input  logic [3:0]            qcount_i,
  input  logic [7:0]            qdepth_i,
  input  tmqs_pkg::tmqs_cmd_t   cmd_i,
  output tmqs_pkg::tmqs_sts_t   sts_o
);
  import tmqs_pkg::*;

  // slot table
  logic signed [31:0] slot_type_q [NUM_QUEUES];
  logic [DEPTH_W-1:0] head_q      [NUM_QUEUES];
  logic [CNT_W-1:0]   count_q     [NUM_QUEUES];

  // captured request
  logic               op_q;
  logic signed [31:0] kind_q;
  logic [LEN_W-1:0]   len_q;

  // staging
  logic [63:0]        stg_mem [MSG_WORDS];
  logic [NW_W-1:0]    stg_idx_q;
  logic [63:0]        stg_rd_q;

  // stores
  logic [LEN_W-1:0]   len_mem [NUM_QUEUES*QUEUE_DEPTH];
  logic [63:0]        pay_mem [NUM_QUEUES*QUEUE_DEPTH*MSG_WORDS];
  logic [LEN_W-1:0]   len_rd_q;
  logic [63:0]        pay_rd_q;

  // transfer control
  logic [SLOT_W-1:0]  sel_q;
  logic [ENT_W-1:0]   e_q;
  logic [NW_W-1:0]    widx_q;
  logic [NW_W-1:0]    nw_q;
  logic               wr_vld_q;
  logic [WIDX_W-1:0]  wr_idx_q;
  logic               keep_q;
  tmqs_status_e       resp_q;

  // result register
  logic               out_vld_q;
  logic [2:0]         out_st_q;
  logic [63:0]        out_word_q;
  logic [LEN_W-1:0]   out_len_q;
  logic               out_last_q;

  // lookup
  logic               hit_m, hit_f, hit_r;
  logic [SLOT_W-1:0]  idx_m, idx_f, idx_r, sel_s, sel;
  logic signed [32:0] mag;
  logic               kind_pos, kind_neg, rmatch;
  logic [15:0]        depth_eff, pos_sum;
  logic [DEPTH_W-1:0] pos;
  logic               bad;
  tmqs_status_e       send_st, rec_st, lk_st;
  logic               lk_ok;
  logic [ENT_W-1:0]   ent_idx;
  logic [9:0]         len_rnd_s, len_rnd_r;
  logic [NW_W-1:0]    nw_send, nw_recv;
  logic [PAY_AW-1:0]  pay_wa, pay_ra;
  logic               accept, out_free, copy_last, emit_last, too_small;

  assign accept   = cmd_i.accept & req.valid;
  assign req.ready = cmd_i.accept;
  assign out_free = ~out_vld_q | rsp.ready;

  assign kind_pos = ~kind_q[31] & (kind_q != 32'sd0);
  assign kind_neg = kind_q[31];
  assign mag      = -($signed({kind_q[31], kind_q}));

  // first matching slot, first free slot, first receive match
  always_comb begin
    hit_m = 1'b0; hit_f = 1'b0; hit_r = 1'b0;
    idx_m = '0;   idx_f = '0;   idx_r = '0;
    rmatch = 1'b0;
    for (int s = NUM_QUEUES - 1; s >= 0; s--) begin
      if (s < int'(qcount_i)) begin
        if (slot_type_q[s] == kind_q) begin
          hit_m = 1'b1; idx_m = SLOT_W'(s);
        end
        if (slot_type_q[s] == 32'sd0) begin
          hit_f = 1'b1; idx_f = SLOT_W'(s);
        end
        if (kind_pos)
          rmatch = (slot_type_q[s] == kind_q);
        else if (kind_neg)
          rmatch = (slot_type_q[s] > 0) &&
                   ($signed({slot_type_q[s][31], slot_type_q[s]}) <= mag);
        else
          rmatch = (slot_type_q[s] != 32'sd0);
        if (rmatch) begin
          hit_r = 1'b1; idx_r = SLOT_W'(s);
        end
      end
    end
  end

  assign depth_eff = (16'(qdepth_i) > 16'(QUEUE_DEPTH)) ? 16'(QUEUE_DEPTH) : 16'(qdepth_i);
  assign sel_s     = hit_m ? idx_m : idx_f;
  assign bad       = ~kind_pos | (len_q == '0) | (32'(len_q) > MAX_BYTES);

  always_comb begin
    if (bad)                                    send_st = ST_BAD;
    else if (!hit_m && !hit_f)                  send_st = ST_MAPFULL;
    else if (16'(count_q[sel_s]) >= depth_eff)  send_st = ST_QFULL;
    else                                        send_st = ST_OK;
  end

  assign rec_st = (!hit_r || count_q[idx_r] == '0) ? ST_EMPTY : ST_OK;
  assign lk_st  = (op_q == OP_RECV) ? rec_st : send_st;
  assign lk_ok  = (lk_st == ST_OK);
  assign sel    = (op_q == OP_RECV) ? idx_r : sel_s;

  // send appends behind the tail; receive reads the head
  always_comb begin
    pos_sum = 16'(head_q[sel]);
    if (op_q == OP_SEND) pos_sum = 16'(head_q[sel]) + 16'(count_q[sel]);
    if (pos_sum >= 16'(QUEUE_DEPTH)) pos_sum = pos_sum - 16'(QUEUE_DEPTH);
    pos = DEPTH_W'(pos_sum);
  end
  assign ent_idx = ENT_W'(32'(sel) * QUEUE_DEPTH + 32'(pos));

  assign len_rnd_s = {1'b0, len_q} + 10'd7;
  assign nw_send   = NW_W'(len_rnd_s >> 3);
  assign len_rnd_r = {1'b0, len_rd_q} + 10'd7;
  always_comb begin
    if ((len_rnd_r >> 3) == 10'd0)                 nw_recv = NW_W'(1);
    else if (32'(len_rnd_r >> 3) > MSG_WORDS)      nw_recv = NW_W'(MSG_WORDS);
    else                                           nw_recv = NW_W'(len_rnd_r >> 3);
  end

  assign copy_last = (widx_q == nw_q - NW_W'(1));
  assign emit_last = ((widx_q + NW_W'(1)) == nw_q);
  assign too_small = (len_q < len_rd_q);

  assign pay_wa = PAY_AW'(32'(e_q) * MSG_WORDS + 32'(wr_idx_q));
  assign pay_ra = PAY_AW'(32'(e_q) * MSG_WORDS + 32'(widx_q[WIDX_W-1:0]));

  // slot table
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NUM_QUEUES; s++) begin
        slot_type_q[s] <= '0;
        head_q[s]      <= '0;
        count_q[s]     <= '0;
      end
    end else if (cmd_i.lookup && lk_ok && op_q == OP_SEND) begin
      slot_type_q[sel] <= kind_q;
      count_q[sel]     <= count_q[sel] + CNT_W'(1);
    end else if (cmd_i.emit && emit_last) begin
      head_q[sel_q]  <= (head_q[sel_q] == DEPTH_W'(QUEUE_DEPTH - 1)) ? '0
                        : head_q[sel_q] + DEPTH_W'(1);
      count_q[sel_q] <= count_q[sel_q] - CNT_W'(1);
      if (count_q[sel_q] == CNT_W'(1)) slot_type_q[sel_q] <= '0;
    end
  end

  // staging index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_idx_q <= '0;
    end else if (cmd_i.copy_fl || (cmd_i.lookup && !lk_ok && op_q == OP_SEND)) begin
      stg_idx_q <= '0;
    end else if (accept && req.op == OP_SEND && stg_idx_q < NW_W'(MSG_WORDS)) begin
      stg_idx_q <= stg_idx_q + NW_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && req.op == OP_SEND && stg_idx_q < NW_W'(MSG_WORDS))
      stg_mem[stg_idx_q[WIDX_W-1:0]] <= req.data_word;
    stg_rd_q <= stg_mem[widx_q[WIDX_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup && lk_ok && op_q == OP_SEND) len_mem[ent_idx] <= len_q;
    len_rd_q <= len_mem[e_q];
  end

  always_ff @(posedge clk_i) begin
    if (wr_vld_q) pay_mem[pay_wa] <= keep_q ? stg_rd_q : 64'd0;
    pay_rd_q <= pay_mem[pay_ra];
  end

  // request capture and transfer bookkeeping
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= req.op;
      kind_q <= req.msg_kind;
      len_q  <= req.byte_length;
    end
    if (cmd_i.lookup) begin
      if (lk_ok) begin
        sel_q  <= sel;
        e_q    <= ent_idx;
        nw_q   <= nw_send;
        widx_q <= '0;
      end else begin
        resp_q <= lk_st;
      end
    end
    if (cmd_i.len_chk) begin
      if (too_small) begin
        resp_q <= ST_SMALL;
      end else begin
        nw_q   <= nw_recv;
        widx_q <= '0;
      end
    end
    if (cmd_i.copy || cmd_i.emit) widx_q <= widx_q + NW_W'(1);
    if (cmd_i.copy_fl) resp_q <= ST_OK;
    wr_idx_q <= widx_q[WIDX_W-1:0];
    keep_q   <= (widx_q < stg_idx_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) wr_vld_q <= 1'b0;
    else         wr_vld_q <= cmd_i.copy;
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)                       out_vld_q <= 1'b0;
    else if (cmd_i.emit || cmd_i.resp) out_vld_q <= 1'b1;
    else if (rsp.ready)                out_vld_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_st_q   <= ST_OK;
      out_word_q <= pay_rd_q;
      out_len_q  <= len_rd_q;
      out_last_q <= emit_last;
    end else if (cmd_i.resp) begin
      out_st_q   <= resp_q;
      out_word_q <= '0;
      out_len_q  <= '0;
      out_last_q <= 1'b1;
    end
  end

  assign rsp.valid      = out_vld_q;
  assign rsp.status     = out_st_q;
  assign rsp.out_word   = out_word_q;
  assign rsp.out_length = out_len_q;
  assign rsp.out_last   = out_last_q;

  assign sts_o.in_valid  = req.valid;
  assign sts_o.in_op     = req.op;
  assign sts_o.in_last   = req.last_word;
  assign sts_o.op        = op_q;
  assign sts_o.lk_ok     = lk_ok;
  assign sts_o.copy_last = copy_last;
  assign sts_o.too_small = too_small;
  assign sts_o.emit_last = emit_last;
  assign sts_o.out_free  = out_free;

  a_stg_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stg_idx_q <= NW_W'(MSG_WORDS))
    else $error("staging index past buffer");

  a_err_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_st_q != ST_OK |-> out_last_q)
    else $error("error result not final");

  for (genvar g = 0; g < NUM_QUEUES; g++) begin : g_slot_chk
    a_slot_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (count_q[g] == '0) == (slot_type_q[g] == 32'sd0))
      else $error("slot type and fill disagree");
  end

endmodule

// ===== src/tmqs_ctrl.sv =====
// Controller: sequences lookup, commit copy and receive streaming.
module tmqs_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tmqs_pkg::tmqs_sts_t sts_i,
  output tmqs_pkg::tmqs_cmd_t cmd_o
);
  import tmqs_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_LOOKUP  = 9'b000000010,
    S_COPY    = 9'b000000100,
    S_COPY_FL = 9'b000001000,
    S_LEN_RD  = 9'b000010000,
    S_LEN_CHK = 9'b000100000,
    S_EMIT_RD = 9'b001000000,
    S_EMIT_WR = 9'b010000000,
    S_RESP    = 9'b100000000
  } tmqs_state_e;

  tmqs_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        cmd_o.accept = 1'b1;
        if (sts_i.in_valid && (sts_i.in_op == OP_RECV || sts_i.in_last))
          state_d = S_LOOKUP;
      end
      S_LOOKUP: begin
        cmd_o.lookup = 1'b1;
        if (!sts_i.lk_ok)              state_d = S_RESP;
        else if (sts_i.op == OP_RECV)  state_d = S_LEN_RD;
        else                           state_d = S_COPY;
      end
      S_COPY: begin
        cmd_o.copy = 1'b1;
        if (sts_i.copy_last) state_d = S_COPY_FL;
      end
      S_COPY_FL: begin
        cmd_o.copy_fl = 1'b1;
        state_d = S_RESP;
      end
      S_LEN_RD: state_d = S_LEN_CHK;
      S_LEN_CHK: begin
        cmd_o.len_chk = 1'b1;
        state_d = sts_i.too_small ? S_RESP : S_EMIT_RD;
      end
      S_EMIT_RD: state_d = S_EMIT_WR;
      S_EMIT_WR: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d = sts_i.emit_last ? S_IDLE : S_EMIT_RD;
        end
      end
      S_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.resp = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  a_len_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_LEN_CHK |-> $past(state_q) == S_LEN_RD)
    else $error("length check without length read");

  a_flush_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_COPY_FL |-> $past(state_q) == S_COPY)
    else $error("copy flush without copy");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit || cmd_o.resp |-> sts_i.out_free)
    else $error("result loaded into busy register");

endmodule

// ===== src/typed_message_queue_store_top.sv =====
// Top level of the typed message queue store: config registers and core.
// Sequence: a non-final send word is taken in the idle state. A commit runs slot lookup,
//   one copy step per staged word, flush and result, with nw = ceil(length/8); a receive runs
//   lookup, length read and length check, then a read step and an emit step per word.
// Throughput: one request at a time; the payload memory and the one-word-per-cycle
//   staging copy set the rate.
// Reset (rst_ni low, asynchronous): all slots free, queues empty, staging empty,
//   queue_count_in_use = 5, queue_depth_in_use = 100; stores need no clearing.
module typed_message_queue_store_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tmqs_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  tmqs_req_if.sink                     req_i,
  tmqs_rsp_if.source                   rsp_o
);
  import tmqs_pkg::*;

  logic [3:0] qcount_q;
  logic [7:0] qdepth_q;
  logic       reg_wr;
  tmqs_cmd_t  cmd;
  tmqs_sts_t  sts;

  // register index sits at paddr[2]; low address bits are ignored
  assign reg_wr = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qcount_q <= QCOUNT_RST;
      qdepth_q <= QDEPTH_RST;
    end else if (reg_wr) begin
      case (paddr[2])
        REG_QCOUNT: qcount_q <= pwdata[3:0];
        REG_QDEPTH: qdepth_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_QCOUNT: prdata = {28'd0, qcount_q};
      REG_QDEPTH: prdata = {24'd0, qdepth_q};
      default:    prdata = '0;
    endcase
  end

  tmqs_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  tmqs_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req      (req_i),
    .rsp      (rsp_o),
    .qcount_i (qcount_q),
    .qdepth_i (qdepth_q),
    .cmd_i    (cmd),
    .sts_o    (sts)
  );

endmodule
